// ===== src/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
`default_nettype none

package tcw_pkg;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } tcw_op_e;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] ATTR_RESET   = 8'd15;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  char_code;
    logic [10:0] cell_address;
  } tcw_in_t;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic [15:0] cell_data;
  } tcw_out_t;

endpackage

`default_nettype wire

// ===== src/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcw_ram #(
  parameter int Width = 16,
  parameter int Depth = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/tcw_seq.sv =====
// Operation sequencer: cursor update, scroll copy, blanking walks and cell reads.
`default_nettype none

module tcw_seq
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  localparam int Cells  = COLUMNS * ROWS,
  localparam int Aw     = $clog2(Cells),
  localparam int Cw     = $clog2(COLUMNS)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire tcw_in_t       item_i,
  input  wire logic [7:0]    attr_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [Aw-1:0]      cursor_o,
  output logic [15:0]        data_o,
  output logic               ram_we_o,
  output logic [Aw-1:0]      ram_waddr_o,
  output logic [15:0]        ram_wdata_o,
  output logic [Aw-1:0]      ram_raddr_o,
  input  wire logic [15:0]   ram_rdata_i
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_SCR_RD = 7'b0000100,
    S_SCR_WR = 7'b0001000,
    S_BLANK  = 7'b0010000,
    S_READ   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  localparam logic [Aw-1:0] LastCell    = Aw'(Cells - 1);
  localparam logic [Aw-1:0] LastRowBase = Aw'(Cells - COLUMNS);
  localparam logic [Aw-1:0] LastCopy    = Aw'(Cells - COLUMNS - 1);
  localparam logic [Aw-1:0] ColsA       = Aw'(COLUMNS);
  localparam logic [Cw-1:0] LastCol     = Cw'(COLUMNS - 1);

  state_e        state_q, state_d;
  logic [Aw-1:0] cnt_q, cnt_d;
  logic [Aw-1:0] cursor_q, cursor_d;
  logic [Cw-1:0] col_q, col_d;
  tcw_in_t       item_q;
  logic [15:0]   data_q, data_d;

  logic [Aw+10:0] addr_ext;
  logic           addr_ok;
  logic           last_row;
  logic [15:0]    blank_cell;
  tcw_op_e        op;

  assign addr_ext   = {{Aw{1'b0}}, item_q.cell_address};
  assign addr_ok    = addr_ext < (Aw + 11)'(Cells);
  assign last_row   = cursor_q >= LastRowBase;
  assign blank_cell = {attr_i, CH_SPACE};
  assign op         = tcw_op_e'(item_q.operation);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cursor_d    = cursor_q;
    col_d       = col_q;
    data_d      = data_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = cnt_q;
    ram_wdata_o = blank_cell;
    ram_raddr_o = cnt_q + ColsA;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        data_d  = '0;
        state_d = S_DONE;
        case (op)
          OP_PUT: begin
            if (item_q.char_code == CH_NEWLINE) begin
              cursor_d = cursor_q + ColsA - Aw'(col_q);
              col_d    = '0;
              if (last_row) begin
                state_d = S_SCR_RD;
              end
            end else if (item_q.char_code == CH_BACKSPACE) begin
              if (cursor_q != '0) begin
                ram_we_o    = 1'b1;
                ram_waddr_o = cursor_q - 1'b1;
                cursor_d    = cursor_q - 1'b1;
                col_d       = (col_q == '0) ? LastCol : col_q - 1'b1;
              end
            end else begin
              ram_we_o    = 1'b1;
              ram_waddr_o = cursor_q;
              ram_wdata_o = {attr_i, item_q.char_code};
              cursor_d    = cursor_q + 1'b1;
              col_d       = (col_q == LastCol) ? '0 : col_q + 1'b1;
              if (cursor_q == LastCell) begin
                state_d = S_SCR_RD;
              end
            end
            // on scroll: cursor lands on the start of the bottom row
            if (state_d == S_SCR_RD) begin
              cursor_d = LastRowBase;
              col_d    = '0;
              cnt_d    = '0;
            end
          end
          OP_CLEAR: begin
            cursor_d = '0;
            col_d    = '0;
            cnt_d    = '0;
            state_d  = S_BLANK;
          end
          OP_READ: begin
            ram_raddr_o = addr_ext[Aw-1:0];
            if (addr_ok) begin
              state_d = S_READ;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_SCR_RD: begin
        state_d = S_SCR_WR;
      end

      S_SCR_WR: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = ram_rdata_i;
        if (cnt_q == LastCopy) begin
          cnt_d   = LastRowBase;
          state_d = S_BLANK;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_SCR_RD;
        end
      end

      S_BLANK: begin
        ram_we_o = 1'b1;
        if (cnt_q == LastCell) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_READ: begin
        data_d  = ram_rdata_i;
        state_d = S_DONE;
      end

      S_DONE: begin
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cursor_q <= '0;
      col_q    <= '0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      col_q    <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    data_q <= data_d;
    if (state_q == S_IDLE && start_i) begin
      item_q <= item_i;
    end
  end

  assign busy_o   = state_q != S_IDLE;
  assign done_o   = state_q == S_DONE;
  assign cursor_o = cursor_q;
  assign data_o   = data_q;

endmodule

`default_nettype wire

// ===== src/text_console_writer_core.sv =====
// Top level of the text console writer: attribute register, screen RAM, sequencer.
`default_nettype none

// Text console of COLUMNS x ROWS cells (attribute high byte, character low
// byte). Pulse start while busy is low to issue one operation; busy stays high
// until done_o has strobed the result for one cycle, and the next start is
// taken the cycle after. The receiver cannot stall: sample result_o whenever
// done_o is high. Each operation goes through decode to done_o; a read adds
// a RAM read state, a read beyond the screen or an unused code goes straight
// to done, a clear blanks every cell, and a put that scrolls first copies each
// row below the top up by one row, then blanks the bottom row. The cost of
// scroll and clear is set by the single screen RAM port pair, walked one cell
// per cycle for blanking and one read plus one write per cell for the scroll
// copy. Screen contents are undefined after reset until cleared or written.
module text_console_writer_core
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire tcw_in_t  item_i,
  output logic          done_o,
  output tcw_out_t      result_o,
  input  wire logic     cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i
);

  localparam int Cells = COLUMNS * ROWS;
  localparam int Aw    = $clog2(Cells);

  logic [7:0]     attr_q;
  logic [Aw-1:0]  cursor;
  logic [Aw+10:0] cursor_ext;
  logic [15:0]    cell_data;
  logic           ram_we;
  logic [Aw-1:0]  ram_waddr;
  logic [15:0]    ram_wdata;
  logic [Aw-1:0]  ram_raddr;
  logic [15:0]    ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  tcw_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .item_i      (item_i),
    .attr_i      (attr_q),
    .busy_o      (busy),
    .done_o      (done_o),
    .cursor_o    (cursor),
    .data_o      (cell_data),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  tcw_ram #(
    .Width (16),
    .Depth (Cells)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // cursor port carries the low 11 bits of the cursor
  assign cursor_ext               = {11'b0, cursor};
  assign result_o.cursor_position = cursor_ext[10:0];
  assign result_o.cell_data       = cell_data;

endmodule

`default_nettype wire

// ===== src/tcw_checker.sv =====
// Port-level checker for the text console writer, bound to the top level.
`default_nettype none

module tcw_checker
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     done_o,
  input wire tcw_out_t result_o
);

  localparam int Cells = COLUMNS * ROWS;
  localparam int Lim   = (Cells > 2048) ? 2048 : Cells;

  // a result only shows while an operation is in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("done without busy");

  // an accepted beat makes the block busy and never answers in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o)) else $error("accept not followed by busy");

  // one result per beat: after the strobe the block is free again
  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!busy && !done_o)) else $error("busy after done");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ({1'b0, result_o.cursor_position} < 12'(Lim)))
    else $error("cursor beyond screen");

endmodule

bind text_console_writer_core tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);

`default_nettype wire
